@@ hdl/mgcd_pkg.sv @@
// Shared types, constants and the CRC step for the cell-bit decoder.
package mgcd_pkg;

    localparam logic [6:0]  SYNC_LEN   = 7'd64;
    localparam logic [6:0]  SYNC_BACK  = SYNC_LEN - 7'd1;
    localparam logic [6:0]  MARK_START = SYNC_LEN + 7'd1;
    localparam logic [6:0]  MARK_END   = 7'd80;
    localparam logic [6:0]  BYTE_START = MARK_END + 7'd1;
    localparam logic [6:0]  BYTE_END   = 7'd96;
    localparam logic [7:0]  POS_BASE   = 8'd96;
    localparam logic [7:0]  RAW_FILL   = 8'hFF;
    localparam logic [3:0]  MARK_PAT   = 4'h1;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_SEED   = 16'hCDB4;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_mark;
        logic       crc_ok;
    } t_result;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic b);
        logic fb;
        begin
            fb = crc[15] ^ b;
            crc_step = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
    endfunction

endpackage

@@ hdl/mgcd_core.sv @@
// Decoder state registers and the per-cell next-state and result logic.
module mgcd_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_data,
    input  logic            i_fire,
    input  logic            i_cell_bit,
    input  logic            i_restart,
    output logic            o_res_valid,
    output mgcd_pkg::t_result o_res
);
    import mgcd_pkg::*;

    logic        r_gcr_mode;
    logic [7:0]  r_shift, n_shift;
    logic        r_mark, n_mark;
    logic [7:0]  r_raw, n_raw;
    logic [6:0]  r_sync, n_sync;
    logic [15:0] r_crc, n_crc;

    logic [7:0]  gcr_word;
    logic [7:0]  pos_word;
    logic [2:0]  pos;
    logic [6:0]  sync_inc;

    always_comb begin
        n_shift     = r_shift;
        n_mark      = r_mark;
        n_raw       = r_raw;
        n_sync      = r_sync;
        n_crc       = r_crc;
        o_res_valid = 1'b0;
        o_res       = '0;
        gcr_word    = {r_shift[6:0], i_cell_bit};
        pos_word    = POS_BASE - {1'b0, r_sync};
        pos         = pos_word[3:1];
        sync_inc    = r_sync + 7'd1;
        if (i_restart) begin
            n_shift = '0;
            n_mark  = 1'b0;
            n_sync  = '0;
        end else if (r_gcr_mode) begin
            n_mark = 1'b0;
            if (gcr_word[7]) begin
                o_res_valid     = 1'b1;
                o_res.data_byte = gcr_word;
                n_shift         = '0;
            end else begin
                n_shift = gcr_word;
            end
        end else if (r_sync < SYNC_LEN) begin
            n_sync = (i_cell_bit != r_sync[0]) ? sync_inc : 7'd0;
        end else if (r_sync == SYNC_LEN && i_cell_bit) begin
            n_sync = SYNC_BACK;
        end else begin
            if (r_sync == MARK_START || r_sync == BYTE_START) begin
                n_raw   = RAW_FILL;
                n_shift = '0;
                n_mark  = 1'b0;
            end
            if (r_sync[0]) begin
                n_shift = n_shift | ({7'd0, i_cell_bit} << pos);
                n_crc   = crc_step(r_crc, i_cell_bit);
            end
            n_raw = {n_raw[6:0], i_cell_bit};
            if (n_raw[3:0] == MARK_PAT && !r_sync[0]) begin
                n_mark = 1'b1;
            end
            n_sync = sync_inc;
            if (sync_inc == MARK_END) begin
                if (!n_mark) begin
                    n_sync = '0;
                end else begin
                    n_crc           = CRC_SEED;
                    o_res_valid     = 1'b1;
                    o_res.data_byte = n_shift;
                    o_res.is_mark   = 1'b1;
                end
            end else if (sync_inc == BYTE_END) begin
                n_sync          = MARK_END;
                o_res_valid     = 1'b1;
                o_res.data_byte = n_shift;
                o_res.is_mark   = n_mark;
                o_res.crc_ok    = !n_mark && (n_crc == 16'h0000);
                if (n_mark) begin
                    n_crc = CRC_SEED;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gcr_mode <= 1'b0;
            r_shift    <= '0;
            r_mark     <= 1'b0;
            r_raw      <= '0;
            r_sync     <= '0;
            r_crc      <= CRC_INIT;
        end else begin
            if (i_cfg_we) begin
                r_gcr_mode <= i_cfg_data;
            end
            if (i_fire) begin
                r_shift <= n_shift;
                r_mark  <= n_mark;
                r_raw   <= n_raw;
                r_sync  <= n_sync;
                r_crc   <= n_crc;
            end
        end
    end

    a_sync_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sync <= BYTE_END)
        else $error("sync count out of range");

    a_mark_reseed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res_valid && o_res.is_mark) |=> (r_crc == CRC_SEED))
        else $error("crc not reseeded after mark");

    a_restart_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_restart) |=> (r_sync == 7'd0 && r_shift == 8'd0 && !r_mark))
        else $error("restart did not clear state");

    a_gcr_crc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_gcr_mode && !i_cfg_we) |=> $stable(r_crc))
        else $error("crc changed in gcr mode");

    a_ok_not_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.crc_ok) |-> (!o_res.is_mark && !r_gcr_mode))
        else $error("crc ok flagged on mark or gcr byte");

endmodule

@@ hdl/mgcd_out_buf.sv @@
// Result register with a skid stage toward the downstream side.
module mgcd_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mgcd_pkg::t_result i_push_data,
    output logic              o_push_ready,
    output logic              o_valid,
    output mgcd_pkg::t_result o_data,
    input  logic              i_stall
);
    import mgcd_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop          = r_out_valid && !i_stall;
    assign o_push_ready = !r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_data       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= r_skid_valid && i_push;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out <= r_skid_valid ? r_skid : i_push_data;
            if (r_skid_valid && i_push) begin
                r_skid <= i_push_data;
            end
        end else if (i_push) begin
            r_skid <= i_push_data;
        end
    end

endmodule

@@ hdl/mfm_gcr_cell_bit_decoder.sv @@
// Top level of the MFM / GCR cell-bit decoder.
// One raw cell bit is accepted per clock while the input does not stall. Each
// accepted item is held in the input register and updates the decoder state in
// a single pass; a byte it completes is loaded into the result register, or
// into the skid stage while the result register holds a stalled result. The
// skid stage holds one more result while the downstream side stalls; once both
// hold a result, the input stalls until the downstream side takes one.
// i_cfg_data selects GCR framing (1) or MFM decoding (0); write it only while
// the block is idle.
module mfm_gcr_cell_bit_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_cell_bit,
    input  logic       i_restart,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_data_byte,
    output logic       o_is_mark,
    output logic       o_crc_ok
);
    import mgcd_pkg::*;

    logic    r_in_valid;
    logic    r_cell_bit;
    logic    r_restart;
    logic    fire;
    logic    push_ready;
    logic    res_valid;
    t_result res;
    t_result out_data;

    assign fire    = r_in_valid && push_ready;
    assign o_stall = r_in_valid && !push_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_cell_bit <= i_cell_bit;
            r_restart  <= i_restart;
        end
    end

    mgcd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_cell_bit  (r_cell_bit),
        .i_restart   (r_restart),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    mgcd_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (fire && res_valid),
        .i_push_data  (res),
        .o_push_ready (push_ready),
        .o_valid      (o_valid),
        .o_data       (out_data),
        .i_stall      (i_stall)
    );

    assign o_data_byte = out_data.data_byte;
    assign o_is_mark   = out_data.is_mark;
    assign o_crc_ok    = out_data.crc_ok;

endmodule

@@ tb/sv/tb_mfm_gcr_cell_bit_decoder.sv @@
// Self-checking testbench for the MFM / GCR cell-bit decoder: directed table, random streams.
`timescale 1ns / 100ps

module tb_mfm_gcr_cell_bit_decoder;
    import mgcd_pkg::*;

    localparam logic        MFM_MODE     = 1'b0;
    localparam logic        GCR_MODE     = 1'b1;
    localparam logic [15:0] CCITT_POLY   = 16'h1021;
    localparam logic [15:0] CCITT_SEED   = 16'hCDB4;
    localparam logic [15:0] MARK_RAW     = 16'h4489;
    localparam int          ITEM_GOAL    = 1050;
    localparam int          RESULT_GOAL  = 48;
    localparam int          DRAIN_CYCLES = 6;
    localparam int          STUCK_LIMIT  = 500;

    typedef enum {SEC_GOOD, SEC_BAD_CRC, SEC_FAKE_MARK, SEC_NOISE, SEC_BROKEN_SYNC} t_sector_kind;

    typedef struct packed {
        logic       mode;
        logic       cell_val;
        logic       restart;
        logic       known;
        logic       got;
        logic [7:0] data_byte;
        logic       is_mark;
        logic       crc_ok;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [0:23] = '{
        '{GCR_MODE, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{GCR_MODE, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{GCR_MODE, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{GCR_MODE, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{GCR_MODE, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{GCR_MODE, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{GCR_MODE, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{GCR_MODE, 1'b1, 1'b0, 1'b1, 1'b1, 8'hFF, 1'b0, 1'b0},
        '{GCR_MODE, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{GCR_MODE, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{GCR_MODE, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{GCR_MODE, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{GCR_MODE, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{GCR_MODE, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{MFM_MODE, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{MFM_MODE, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{GCR_MODE, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{GCR_MODE, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{GCR_MODE, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{GCR_MODE, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{GCR_MODE, 1'b1, 1'b0, 1'b1, 1'b1, 8'hA1, 1'b0, 1'b0},
        '{GCR_MODE, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{MFM_MODE, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{MFM_MODE, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}
    };

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic       i_cfg_data = 1'b0;
    logic       i_valid    = 1'b0;
    logic       i_cell_bit = 1'b0;
    logic       i_restart  = 1'b0;
    logic       i_stall    = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_data_byte;
    logic       o_is_mark;
    logic       o_crc_ok;

    logic        dec_mode  = MFM_MODE;
    logic [7:0]  dec_shift = 8'h00;
    logic        dec_mark  = 1'b0;
    logic [7:0]  dec_raw   = 8'h00;
    logic [6:0]  dec_sync  = 7'd0;
    logic [15:0] dec_crc   = 16'hFFFF;

    t_result pending_bytes [$];
    logic    in_fire  = 1'b0;
    logic    out_fire = 1'b0;
    logic    mfm_prev_data = 1'b0;
    int      src_calm = 0;
    int      sink_calm = 0;
    int      stuck_cycles = 0;
    int      error_count = 0;
    int      cells_sent = 0;
    int      restarts_sent = 0;
    int      sectors_sent = 0;
    int      gcr_phases = 0;
    int      bytes_checked = 0;
    int      marks_checked = 0;
    int      crc_good = 0;

    mfm_gcr_cell_bit_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cell_bit  (i_cell_bit),
        .i_restart   (i_restart),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data_byte (o_data_byte),
        .o_is_mark   (o_is_mark),
        .o_crc_ok    (o_crc_ok)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [15:0] ccitt_bit(input logic [15:0] crc, input logic b);
        return {crc[14:0], 1'b0} ^ ((crc[15] ^ b) ? CCITT_POLY : 16'h0000);
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic decode_cell(input logic cell_val, input logic rst_cmd,
                               output logic got, output t_result r);
        logic [6:0] c;
        logic [7:0] pos_w;
        logic       ok;
        got = 1'b0;
        r   = '0;
        if (rst_cmd) begin
            dec_shift = 8'h00;
            dec_mark  = 1'b0;
            dec_sync  = 7'd0;
            return;
        end
        if (dec_mode == GCR_MODE) begin
            dec_shift = {dec_shift[6:0], cell_val};
            dec_mark  = 1'b0;
            if (dec_shift[7]) begin
                got       = 1'b1;
                r         = {dec_shift, 1'b0, 1'b0};
                dec_shift = 8'h00;
            end
            return;
        end
        c = dec_sync;
        if (c < 7'd64) begin
            dec_sync = (cell_val != c[0]) ? c + 7'd1 : 7'd0;
            return;
        end
        if (c == 7'd64 && cell_val) begin
            dec_sync = 7'd63;
            return;
        end
        if (c == 7'd65 || c == 7'd81) begin
            dec_raw   = 8'hFF;
            dec_shift = 8'h00;
            dec_mark  = 1'b0;
        end
        if (c[0]) begin
            pos_w = 8'd96 - {1'b0, c};
            dec_shift[pos_w[3:1]] = dec_shift[pos_w[3:1]] | cell_val;
            dec_crc = ccitt_bit(dec_crc, cell_val);
        end
        dec_raw = {dec_raw[6:0], cell_val};
        if (dec_raw[3:0] == 4'h1 && !c[0])
            dec_mark = 1'b1;
        c = c + 7'd1;
        dec_sync = c;
        if (c == 7'd80) begin
            if (!dec_mark) begin
                dec_sync = 7'd0;
                return;
            end
            dec_crc = CCITT_SEED;
            got     = 1'b1;
            r       = {dec_shift, 1'b1, 1'b0};
        end else if (c == 7'd96) begin
            ok       = 1'b0;
            dec_sync = 7'd80;
            if (dec_mark)
                dec_crc = CCITT_SEED;
            else
                ok = (dec_crc == 16'h0000);
            got = 1'b1;
            r   = {dec_shift, dec_mark, ok};
        end
    endtask

    task automatic send_item(input logic cell_val, input logic rst_cmd, input logic use_typed,
                             input logic typed_got, input t_result typed_r);
        int      gap;
        logic    got;
        t_result r;
        if (src_calm > 0) begin
            gap = 0;
            src_calm--;
        end else begin
            gap = $urandom_range(0, 5);
            if ($urandom_range(0, 39) == 0)
                src_calm = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cell_bit <= cell_val;
        i_restart  <= rst_cmd;
        do @(posedge i_clk); while (!in_fire);
        decode_cell(cell_val, rst_cmd, got, r);
        if (use_typed) begin
            got = typed_got;
            r   = typed_r;
        end
        if (got)
            pending_bytes.insert(pending_bytes.size(), r);
        cells_sent++;
        if (rst_cmd)
            restarts_sent++;
    endtask

    task automatic send_cell(input logic cell_val, input logic rst_cmd);
        send_item(cell_val, rst_cmd, 1'b0, 1'b0, '0);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic m);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dec_mode = m;
    endtask

    task automatic send_mfm_byte(input logic [7:0] b);
        logic d;
        for (int i = 7; i >= 0; i--) begin
            d = b[i];
            send_cell(!(mfm_prev_data | d), 1'b0);
            send_cell(d, 1'b0);
            mfm_prev_data = d;
        end
    endtask

    task automatic send_mfm_mark();
        for (int i = 15; i >= 0; i--)
            send_cell(MARK_RAW[i], 1'b0);
        mfm_prev_data = 1'b1;
    endtask

    task automatic send_sector();
        t_sector_kind kind;
        int           pick;
        logic [15:0]  crc;
        logic [7:0]   b;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            kind = SEC_GOOD;
        else if (pick == 6)
            kind = SEC_BAD_CRC;
        else if (pick == 7)
            kind = SEC_FAKE_MARK;
        else if (pick == 8)
            kind = SEC_NOISE;
        else
            kind = SEC_BROKEN_SYNC;
        send_cell(1'($urandom_range(0, 1)), 1'b1);
        mfm_prev_data = 1'b0;
        sectors_sent++;
        case (kind)
            SEC_NOISE: begin
                repeat ($urandom_range(20, 80)) send_cell(1'($urandom_range(0, 1)), 1'b0);
            end
            SEC_BROKEN_SYNC: begin
                repeat ($urandom_range(1, 3)) send_mfm_byte(8'h00);
                b = 8'($urandom);
                send_mfm_byte(b);
                send_mfm_mark();
                b = 8'($urandom);
                send_mfm_byte(b);
            end
            default: begin
                repeat ($urandom_range(4, 6)) send_mfm_byte(8'h00);
                if (kind == SEC_FAKE_MARK)
                    send_mfm_byte(8'hA1);
                repeat ($urandom_range(1, 3)) send_mfm_mark();
                crc = CCITT_SEED;
                repeat ($urandom_range(1, 6)) begin
                    pick = $urandom_range(0, 7);
                    b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
                    for (int i = 7; i >= 0; i--)
                        crc = ccitt_bit(crc, b[i]);
                    send_mfm_byte(b);
                end
                if (kind == SEC_BAD_CRC)
                    crc = crc ^ (16'h0001 << $urandom_range(0, 15));
                send_mfm_byte(crc[15:8]);
                send_mfm_byte(crc[7:0]);
                repeat ($urandom_range(0, 2)) begin
                    b = 8'($urandom);
                    send_mfm_byte(b);
                end
            end
        endcase
    endtask

    task automatic send_gcr_burst();
        repeat ($urandom_range(60, 160))
            send_cell(1'($urandom_range(0, 1)), $urandom_range(0, 39) == 0);
    endtask

    always @(negedge i_clk) begin : result_check
        t_result seen;
        t_result want;
        in_fire  = (i_valid === 1'b1) && (o_stall === 1'b0);
        out_fire = i_rst_n && (o_valid === 1'b1) && !i_stall;
        if (out_fire) begin
            seen = {o_data_byte, o_is_mark, o_crc_ok};
            if (pending_bytes.size() == 0) begin
                flag_error($sformatf("unexpected byte %02h", seen.data_byte));
            end else begin
                want = pending_bytes.pop_front();
                if (seen.data_byte !== want.data_byte)
                    flag_error($sformatf("data_byte %02h, want %02h",
                                         seen.data_byte, want.data_byte));
                if (seen.is_mark !== want.is_mark)
                    flag_error($sformatf("is_mark %b, want %b", seen.is_mark, want.is_mark));
                if (seen.crc_ok !== want.crc_ok)
                    flag_error($sformatf("crc_ok %b, want %b", seen.crc_ok, want.crc_ok));
                bytes_checked++;
                if (want.is_mark)
                    marks_checked++;
                if (want.crc_ok)
                    crc_good++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (in_fire || out_fire)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", STUCK_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : result_sink
        int hold;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (sink_calm > 0) begin
                hold = 0;
                sink_calm--;
            end else begin
                hold = $urandom_range(0, 5);
                if ($urandom_range(0, 39) == 0)
                    sink_calm = $urandom_range(20, 60);
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!out_fire);
        end
    end

    initial begin : stimulus
        t_dir_row row;
        logic     next_mode;
        int       phase_no;
        phase_no = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_mode(MFM_MODE);

        for (int k = 0; k < 24; k++) begin
            row = DIR_ROWS[k];
            if (row.mode != dec_mode) begin
                wait_idle();
                set_mode(row.mode);
            end
            send_item(row.cell_val, row.restart, row.known, row.got,
                      {row.data_byte, row.is_mark, row.crc_ok});
        end

        while (cells_sent < ITEM_GOAL || bytes_checked < RESULT_GOAL) begin
            next_mode = phase_no[0] ^ ($urandom_range(0, 3) == 0);
            wait_idle();
            set_mode(next_mode);
            if (next_mode == GCR_MODE) begin
                gcr_phases++;
                send_gcr_burst();
            end else begin
                repeat ($urandom_range(1, 3)) send_sector();
            end
            phase_no++;
        end

        wait_idle();
        $display("Sent %0d cell items (%0d restarts) over %0d MFM sectors and %0d GCR bursts",
                 cells_sent, restarts_sent, sectors_sent, gcr_phases);
        $display("Checked %0d bytes: %0d marks, %0d with CRC zero",
                 bytes_checked, marks_checked, crc_good);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/mgcd_pkg.sv
hdl/mgcd_core.sv
hdl/mgcd_out_buf.sv
hdl/mfm_gcr_cell_bit_decoder.sv
tb/sv/tb_mfm_gcr_cell_bit_decoder.sv
